FILE: rtl/core/bdl_pkg.sv
// ----------------------------------------------------------------------------
// bdl_pkg
// Shared constants and types for the button debouncer with lockout.
// ----------------------------------------------------------------------------
package bdl_pkg;

    localparam int unsigned NUM_BUTTONS_DEF = 4;
    localparam int unsigned COUNT_WIDTH_DEF = 16;

    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned CFG_INDEX_W = 2;

    typedef logic [CFG_DATA_W-1:0]  cfg_data_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    // register indexes of the configuration port
    localparam cfg_index_t REG_DEBOUNCE      = 2'd0;
    localparam cfg_index_t REG_REFRACTORY    = 2'd1;
    localparam cfg_index_t REG_UNSTABLE_HOLD = 2'd2;
    localparam cfg_index_t REG_PRESSED_LEVEL = 2'd3;

    // reset values of the configuration registers
    localparam cfg_data_t DEBOUNCE_RST      = 16'd20;
    localparam cfg_data_t REFRACTORY_RST    = 16'd50;
    localparam cfg_data_t UNSTABLE_HOLD_RST = 16'd5;
    localparam logic      PRESSED_LEVEL_RST = 1'b0;

endpackage

FILE: rtl/core/bdl_levels_if.sv
// ----------------------------------------------------------------------------
// bdl_levels_if
// Tick channel carrying the raw button levels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bdl_levels_if #(
    parameter int unsigned NUM_BUTTONS = bdl_pkg::NUM_BUTTONS_DEF
) ();
    logic                   valid;
    logic                   ready;
    logic [NUM_BUTTONS-1:0] button_levels;

    modport source (output valid, output button_levels, input ready);
    modport sink   (input valid, input button_levels, output ready);
endinterface

FILE: rtl/core/bdl_events_if.sv
// ----------------------------------------------------------------------------
// bdl_events_if
// Result channel carrying press/release events and the debounced state.
// ----------------------------------------------------------------------------
interface bdl_events_if #(
    parameter int unsigned NUM_BUTTONS = bdl_pkg::NUM_BUTTONS_DEF
) ();
    logic                   valid;
    logic                   ready;
    logic [NUM_BUTTONS-1:0] down_events;
    logic [NUM_BUTTONS-1:0] up_events;
    logic [NUM_BUTTONS-1:0] pressed_mask;

    modport source (output valid, output down_events, output up_events,
                    output pressed_mask, input ready);
    modport sink   (input valid, input down_events, input up_events,
                    input pressed_mask, output ready);
endinterface

FILE: rtl/core/button_debounce_lockout.sv
// A tick beat goes to the input register, then to the result register once that is
// free or being read; per-button decrements and compares are the single logic stage
// between the two. Throughput: one tick per cycle unless the result side stalls.
// A full result register does not stall input while the input register is free.
// Reset (rst_n low, asynchronous): all buttons released, idle, no lockout, and the
// configuration registers return to debounce 20, refractory 50, unstable hold 5.
// ----------------------------------------------------------------------------
// button_debounce_lockout
// Four-button (by default) debouncer with per-button sample/resample check
// and lockout after a release or after disagreeing samples.
// ----------------------------------------------------------------------------
module button_debounce_lockout #(
    parameter int unsigned NUM_BUTTONS = bdl_pkg::NUM_BUTTONS_DEF,
    parameter int unsigned COUNT_WIDTH = bdl_pkg::COUNT_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    bdl_levels_if.sink          levels,
    bdl_events_if.source        events,
    input  logic                cfg_wr_en,
    input  bdl_pkg::cfg_index_t cfg_index,
    input  bdl_pkg::cfg_data_t  cfg_wdata
);
    import bdl_pkg::*;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    cfg_data_t debounce_reg;
    cfg_data_t refractory_reg;
    cfg_data_t unstable_hold_reg;
    logic      pressed_level_reg;

    cfg_data_t debounce_eff;
    count_t    debounce_load;
    count_t    refractory_load;
    count_t    unstable_load;

    logic                   stage_valid_reg;
    logic [NUM_BUTTONS-1:0] stage_levels_reg;
    logic                   out_valid_reg;
    logic [NUM_BUTTONS-1:0] down_reg;
    logic [NUM_BUTTONS-1:0] up_reg;
    logic [NUM_BUTTONS-1:0] mask_reg;

    wire  [NUM_BUTTONS-1:0] down_next;
    wire  [NUM_BUTTONS-1:0] up_next;
    wire  [NUM_BUTTONS-1:0] mask_next;

    logic advance;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg      <= DEBOUNCE_RST;
            refractory_reg    <= REFRACTORY_RST;
            unstable_hold_reg <= UNSTABLE_HOLD_RST;
            pressed_level_reg <= PRESSED_LEVEL_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_DEBOUNCE:      debounce_reg      <= cfg_wdata;
                REG_REFRACTORY:    refractory_reg    <= cfg_wdata;
                REG_UNSTABLE_HOLD: unstable_hold_reg <= cfg_wdata;
                REG_PRESSED_LEVEL: pressed_level_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // a zero debounce acts as one tick
    assign debounce_eff = (debounce_reg == '0) ? cfg_data_t'(1) : debounce_reg;

    // saturate loaded counts at the counter width
    generate
        if (COUNT_WIDTH >= CFG_DATA_W)
        begin : g_wide_count
            assign debounce_load   = count_t'(debounce_eff);
            assign refractory_load = count_t'(refractory_reg);
            assign unstable_load   = count_t'(unstable_hold_reg);
        end
        else
        begin : g_narrow_count
            assign debounce_load   = (debounce_eff[CFG_DATA_W-1:COUNT_WIDTH] != '0) ?
                                     '1 : debounce_eff[COUNT_WIDTH-1:0];
            assign refractory_load = (refractory_reg[CFG_DATA_W-1:COUNT_WIDTH] != '0) ?
                                     '1 : refractory_reg[COUNT_WIDTH-1:0];
            assign unstable_load   = (unstable_hold_reg[CFG_DATA_W-1:COUNT_WIDTH] != '0) ?
                                     '1 : unstable_hold_reg[COUNT_WIDTH-1:0];
        end
    endgenerate

    // ------------------------------------------------------------------
    // handshake: input register, then result register
    // ------------------------------------------------------------------
    assign advance      = stage_valid_reg && (!out_valid_reg || events.ready);
    assign levels.ready = !stage_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (levels.valid && levels.ready)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (levels.valid && levels.ready)
        begin
            stage_levels_reg <= levels.button_levels;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (events.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            down_reg <= down_next;
            up_reg   <= up_next;
            mask_reg <= mask_next;
        end
    end

    assign events.valid        = out_valid_reg;
    assign events.down_events  = down_reg;
    assign events.up_events    = up_reg;
    assign events.pressed_mask = mask_reg;

    // ------------------------------------------------------------------
    // per-button check, all buttons in parallel
    // ------------------------------------------------------------------
    generate
        for (genvar i = 0; i < NUM_BUTTONS; i++)
        begin : g_btn
            logic   last_reg,    last_next;
            logic   pend_reg,    pend_next;
            logic   active_reg,  active_next;
            logic   first_reg,   first_next;
            logic   pressed_reg, pressed_next;
            count_t wait_reg,    wait_next;
            count_t lock_reg,    lock_next;
            logic   down_bit;
            logic   up_bit;
            logic   lvl;

            assign lvl = stage_levels_reg[i];

            always_comb
            begin
                lock_next    = lock_reg;
                wait_next    = wait_reg;
                active_next  = active_reg;
                first_next   = first_reg;
                pressed_next = pressed_reg;
                down_bit     = 1'b0;
                up_bit       = 1'b0;

                if (lock_next != '0)
                begin
                    lock_next = lock_next - 1'b1;
                end

                last_next = lvl;
                pend_next = pend_reg | (lvl != last_reg);

                // running check: count down, then resample
                if (active_reg)
                begin
                    if (wait_next != '0)
                    begin
                        wait_next = wait_next - 1'b1;
                    end
                    if (wait_next == '0)
                    begin
                        active_next = 1'b0;
                        if (lvl != first_reg)
                        begin
                            lock_next = unstable_load;
                        end
                        else if ((lvl == pressed_level_reg) && !pressed_reg)
                        begin
                            pressed_next = 1'b1;
                            down_bit     = 1'b1;
                        end
                        else if ((lvl != pressed_level_reg) && pressed_reg)
                        begin
                            pressed_next = 1'b0;
                            up_bit       = 1'b1;
                            lock_next    = refractory_load;
                        end
                    end
                end

                // idle with pending edge: start a check unless locked out
                if (!active_next && pend_next)
                begin
                    pend_next = 1'b0;
                    if (lock_next == '0)
                    begin
                        first_next  = lvl;
                        wait_next   = debounce_load;
                        active_next = 1'b1;
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    last_reg    <= 1'b0;
                    pend_reg    <= 1'b0;
                    active_reg  <= 1'b0;
                    first_reg   <= 1'b0;
                    pressed_reg <= 1'b0;
                    wait_reg    <= '0;
                    lock_reg    <= '0;
                end
                else if (advance)
                begin
                    last_reg    <= last_next;
                    pend_reg    <= pend_next;
                    active_reg  <= active_next;
                    first_reg   <= first_next;
                    pressed_reg <= pressed_next;
                    wait_reg    <= wait_next;
                    lock_reg    <= lock_next;
                end
            end

            assign down_next[i] = down_bit;
            assign up_next[i]   = up_bit;
            assign mask_next[i] = pressed_next;
        end
    endgenerate

endmodule

FILE: rtl/core/bdl_checker.sv
// ----------------------------------------------------------------------------
// bdl_checker
// Port-level checks on the result channel of the button debouncer.
// ----------------------------------------------------------------------------
module bdl_checker #(
    parameter int unsigned NUM_BUTTONS = bdl_pkg::NUM_BUTTONS_DEF
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [NUM_BUTTONS-1:0] down_events,
    input logic [NUM_BUTTONS-1:0] up_events,
    input logic [NUM_BUTTONS-1:0] pressed_mask
);
    logic [NUM_BUTTONS-1:0] prev_mask_reg;

    // track the debounced state last delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_mask_reg <= '0;
        end
        else if (out_valid && out_ready)
        begin
            prev_mask_reg <= pressed_mask;
        end
    end

    a_hold_beat : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid &&
        $stable(down_events) && $stable(up_events) && $stable(pressed_mask))
        else $error("result beat changed while stalled");

    a_events_disjoint : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (down_events & up_events) == '0)
        else $error("button pressed and released in the same tick");

    a_events_follow_state : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (down_events & prev_mask_reg) == '0 &&
                      (up_events & ~prev_mask_reg) == '0)
        else $error("event does not match previous debounced state");

    a_mask_update : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pressed_mask == ((prev_mask_reg | down_events) & ~up_events))
        else $error("pressed mask changed without an event");

endmodule

bind button_debounce_lockout bdl_checker #(
    .NUM_BUTTONS (NUM_BUTTONS)
) u_bdl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (events.valid),
    .out_ready    (events.ready),
    .down_events  (events.down_events),
    .up_events    (events.up_events),
    .pressed_mask (events.pressed_mask)
);

FILE: dv/tb_button_debounce_lockout.sv
// ----------------------------------------------------------------------------
// tb_button_debounce_lockout
// Self-checking bench for the four-button debouncer with lockout. A driver
// feeds tick beats in random bursts, the result side stalls on its own
// pattern, and a cycle-free predictor of the per-button sample, resample and
// lockout logic is checked against every result beat, field by field. The run
// walks through several register settings, including the extremes.
// ----------------------------------------------------------------------------
module tb_button_debounce_lockout;

    import bdl_pkg::*;

    localparam int unsigned NB = NUM_BUTTONS_DEF;
    localparam int unsigned CW = COUNT_WIDTH_DEF;
    localparam logic [CW-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic [NB-1:0] down;
        logic [NB-1:0] up;
        logic [NB-1:0] mask;
    } btn_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_wr_en = 1'b0;
    cfg_index_t cfg_index = REG_DEBOUNCE;
    cfg_data_t  cfg_wdata = '0;

    bdl_levels_if #(.NUM_BUTTONS(NB)) levels_ch ();
    bdl_events_if #(.NUM_BUTTONS(NB)) events_ch ();

    button_debounce_lockout #(
        .NUM_BUTTONS (NB),
        .COUNT_WIDTH (CW)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .levels    (levels_ch),
        .events    (events_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // predictor copy of the registers and per-button state
    cfg_data_t     deb_cfg   = DEBOUNCE_RST;
    cfg_data_t     refr_cfg  = REFRACTORY_RST;
    cfg_data_t     unst_cfg  = UNSTABLE_HOLD_RST;
    logic          plev_cfg  = PRESSED_LEVEL_RST;
    logic [NB-1:0] last_lvl   = '0;
    logic [NB-1:0] pend       = '0;
    logic [NB-1:0] checking   = '0;
    logic [NB-1:0] sample1    = '0;
    logic [NB-1:0] db_pressed = '0;
    logic [CW-1:0] wait_cnt [NB];
    logic [CW-1:0] lock_cnt [NB];

    logic [NB-1:0] tick_q [$];
    btn_result_t   result_q [$];
    int unsigned   mismatch_cnt = 0;

    // stimulus shaping state: level each button is holding and for how long
    logic [NB-1:0] hold_lvl = '0;
    int unsigned   hold_left [NB];

    initial begin
        for (int i = 0; i < NB; i++)
        begin
            wait_cnt[i]  = '0;
            lock_cnt[i]  = '0;
            hold_left[i] = 0;
        end
        levels_ch.valid         = 1'b0;
        levels_ch.button_levels = '0;
        events_ch.ready         = 1'b0;
    end

    function automatic logic [CW-1:0] sat_count(input logic [31:0] v);
        return (v > CNT_MAX) ? CNT_MAX : v[CW-1:0];
    endfunction

    // advance every button by one tick, return the result beat it causes
    function automatic btn_result_t debounce_tick(input logic [NB-1:0] lv);
        btn_result_t r;
        logic        hit;
        r = '0;
        for (int i = 0; i < NB; i++)
        begin
            if (lock_cnt[i] != '0)
                lock_cnt[i] = lock_cnt[i] - 1'b1;
            if (lv[i] != last_lvl[i])
            begin
                last_lvl[i] = lv[i];
                pend[i]     = 1'b1;
            end
            if (checking[i])
            begin
                if (wait_cnt[i] != '0)
                    wait_cnt[i] = wait_cnt[i] - 1'b1;
                if (wait_cnt[i] == '0)
                begin
                    checking[i] = 1'b0;
                    if (lv[i] != sample1[i])
                        lock_cnt[i] = sat_count(32'(unst_cfg));
                    else
                    begin
                        hit = (lv[i] == plev_cfg);
                        if (hit && !db_pressed[i])
                        begin
                            db_pressed[i] = 1'b1;
                            r.down[i]     = 1'b1;
                        end
                        else if (!hit && db_pressed[i])
                        begin
                            db_pressed[i] = 1'b0;
                            r.up[i]       = 1'b1;
                            lock_cnt[i]   = sat_count(32'(refr_cfg));
                        end
                    end
                end
            end
            // serve a pending edge, possibly in the tick a check just ended
            if (!checking[i] && pend[i])
            begin
                pend[i] = 1'b0;
                if (lock_cnt[i] == '0)
                begin
                    sample1[i]  = lv[i];
                    wait_cnt[i] = sat_count((deb_cfg == '0) ? 32'd1 : 32'(deb_cfg));
                    checking[i] = 1'b1;
                end
            end
        end
        r.mask = db_pressed;
        return r;
    endfunction

    // driver: bursts of beats separated by random gaps
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_ch.valid         <= 1'b0;
            levels_ch.button_levels <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else if (!levels_ch.valid || levels_ch.ready)
        begin
            if (gap_left != 0)
            begin
                gap_left--;
                levels_ch.valid <= 1'b0;
            end
            else if (tick_q.size() != 0)
            begin
                levels_ch.valid         <= 1'b1;
                levels_ch.button_levels <= tick_q.pop_front();
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                end
                else
                    burst_left--;
            end
            else
                levels_ch.valid <= 1'b0;
        end
    end

    // result side stall pattern, picked at random from four modes
    int unsigned stall_mode = 0;
    int unsigned stall_cyc  = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            events_ch.ready <= 1'b0;
            stall_cyc = 0;
        end
        else
        begin
            if (stall_cyc % 50 == 0)
                stall_mode = $urandom_range(0, 3);
            stall_cyc++;
            case (stall_mode)
                0:       events_ch.ready <= 1'b1;
                1:       events_ch.ready <= 1'($urandom_range(0, 1));
                2:       events_ch.ready <= (stall_cyc % 4 != 0);
                default: events_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // monitor: predict on each tick beat, compare each result beat
    always @(posedge clk)
    begin
        btn_result_t want;
        if (rst_n)
        begin
            if (levels_ch.valid && levels_ch.ready)
                result_q.push_back(debounce_tick(levels_ch.button_levels));
            if (events_ch.valid && events_ch.ready)
            begin
                if (result_q.size() == 0)
                begin
                    $display("%0t: unexpected result beat down %h up %h mask %h", $time,
                             events_ch.down_events, events_ch.up_events,
                             events_ch.pressed_mask);
                    mismatch_cnt++;
                end
                else
                begin
                    want = result_q.pop_front();
                    if (events_ch.down_events !== want.down)
                    begin
                        $display("%0t: down_events expected %h got %h", $time,
                                 want.down, events_ch.down_events);
                        mismatch_cnt++;
                    end
                    if (events_ch.up_events !== want.up)
                    begin
                        $display("%0t: up_events expected %h got %h", $time,
                                 want.up, events_ch.up_events);
                        mismatch_cnt++;
                    end
                    if (events_ch.pressed_mask !== want.mask)
                    begin
                        $display("%0t: pressed_mask expected %h got %h", $time,
                                 want.mask, events_ch.pressed_mask);
                        mismatch_cnt++;
                    end
                end
            end
        end
    end

    task automatic wait_idle();
        while (tick_q.size() != 0 || levels_ch.valid || result_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input cfg_data_t val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_DEBOUNCE:      deb_cfg  = val;
            REG_REFRACTORY:    refr_cfg = val;
            REG_UNSTABLE_HOLD: unst_cfg = val;
            REG_PRESSED_LEVEL: plev_cfg = val[0];
            default: ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_config(input cfg_data_t deb, input cfg_data_t refr,
                              input cfg_data_t unst, input logic plev);
        cfg_data_t junk;
        wait_idle();
        junk = cfg_data_t'($urandom_range(0, 16'hFFFF));
        write_reg(REG_DEBOUNCE, deb);
        write_reg(REG_REFRACTORY, refr);
        write_reg(REG_UNSTABLE_HOLD, unst);
        // upper bits of the level write are don't-care; randomize them
        write_reg(REG_PRESSED_LEVEL, {junk[CFG_DATA_W-1:1], plev});
    endtask

    // queue ticks: mostly clean holds long enough to confirm, some bounce,
    // and occasional fully random noise ticks
    task automatic queue_ticks(input int unsigned n);
        int unsigned deb_eff;
        int unsigned pick;
        logic [NB-1:0] lv;
        deb_eff = (deb_cfg == '0) ? 1 : deb_cfg;
        for (int k = 0; k < n; k++)
        begin
            for (int i = 0; i < NB; i++)
            begin
                if (hold_left[i] == 0)
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 6)
                    begin
                        hold_lvl[i]  = ~hold_lvl[i];
                        hold_left[i] = deb_eff + 1 + $urandom_range(0, 15);
                    end
                    else if (pick < 8)
                    begin
                        hold_lvl[i]  = ~hold_lvl[i];
                        hold_left[i] = $urandom_range(1, 2);
                    end
                    else
                    begin
                        hold_lvl[i]  = 1'($urandom_range(0, 1));
                        hold_left[i] = $urandom_range(1, 2 * deb_eff);
                    end
                    if (hold_left[i] > 80)
                        hold_left[i] = 80;
                end
                hold_left[i]--;
            end
            lv = hold_lvl;
            if ($urandom_range(0, 11) == 0)
                lv = NB'($urandom_range(0, 15));
            tick_q.push_back(lv);
        end
    endtask

    initial
    begin
        // under the reset settings: a high first tick is an edge against zero,
        // then edges keep coming while the 20-tick checks run and collapse
        // into one pending flag; the checks end on a mixed level
        static logic [NB-1:0] opening [25] = '{
            4'hF, 4'h0, 4'hF, 4'hA, 4'h5, 4'h0, 4'h3, 4'hC, 4'hF, 4'hF,
            4'hF, 4'hF, 4'h0, 4'h0, 4'h0, 4'h0, 4'hF, 4'hF, 4'hF, 4'hF,
            4'h5, 4'h5, 4'h5, 4'hA, 4'hA
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (opening[k])
            tick_q.push_back(opening[k]);
        wait_idle();
        hold_lvl = 4'hA;

        set_config(16'd0, 16'd3, 16'd0, 1'b0);
        queue_ticks(120);
        set_config(16'd1, 16'd0, 16'd2, 1'b1);
        queue_ticks(120);
        set_config(16'd3, 16'd6, 16'd1, 1'b0);
        queue_ticks(130);
        set_config(DEBOUNCE_RST, REFRACTORY_RST, UNSTABLE_HOLD_RST, PRESSED_LEVEL_RST);
        queue_ticks(150);
        set_config(16'd5, 16'd2, 16'd4, 1'b1);
        queue_ticks(130);
        set_config(16'd1, 16'd1, 16'd1, 1'b0);
        queue_ticks(130);
        // longest lockouts next to last: once hit, a button stays locked for the run
        set_config(16'd2, 16'hFFFF, 16'hFFFF, 1'b1);
        queue_ticks(80);
        set_config(16'hFFFF, 16'd0, 16'd0, 1'b0);
        queue_ticks(25);

        wait_idle();
        repeat (10) @(posedge clk);
        if (result_q.size() != 0)
        begin
            $display("%0t: %0d expected result beats never arrived", $time,
                     result_q.size());
            mismatch_cnt++;
        end
        if (mismatch_cnt == 0)
            $display("button_debounce_lockout verification clean");
        else
            $display("button_debounce_lockout verification failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("%0t: run timed out", $time);
        $display("button_debounce_lockout verification failed");
        $finish;
    end

endmodule
